@@ src/lamp_dither_blink_driver_top_defines.svh @@
// ----------------------------------------------------------------------------
// lamp dither/blink driver assertion macros
// shared assertion forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LAMP_DITHER_BLINK_DRIVER_TOP_DEFINES_SVH
`define LAMP_DITHER_BLINK_DRIVER_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define LDBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define LDBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ldbd_pkg.sv @@
// ----------------------------------------------------------------------------
// ldbd_pkg
// shared types, codes and the brightness dither table of the lamp driver
// ----------------------------------------------------------------------------
package ldbd_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VALID_WNG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WNG  = 2'd2;

	typedef enum logic [3:0] {
		ACT_TICK       = 4'd0,
		ACT_ROT_LEFT   = 4'd1,
		ACT_ROT_RIGHT  = 4'd2,
		ACT_ON         = 4'd3,
		ACT_OFF        = 4'd4,
		ACT_BLINK_SLOW = 4'd5,
		ACT_BLINK_FAST = 4'd6,
		ACT_BLINK_OFF  = 4'd7,
		ACT_SET_ON_OFF = 4'd8,
		ACT_COMBINED   = 4'd9,
		ACT_BRIGHTNESS = 4'd10
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH,
		ST_FILL
	} state_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_ROT_L,
		OP_ROT_R,
		OP_FILL,
		OP_SETALL
	} op_t;

	localparam logic [31:0] LEVEL_TABLE [0:31] = '{
		32'h00000000, 32'h00010001, 32'h00010101, 32'h01010101,
		32'h01010111, 32'h01110111, 32'h01111111, 32'h11111111,
		32'h11111115, 32'h11151115, 32'h11151515, 32'h15151515,
		32'h15151555, 32'h15551555, 32'h15555555, 32'h55555555,
		32'h55555557, 32'h55575557, 32'h55575757, 32'h57575757,
		32'h57575777, 32'h57775777, 32'h57777777, 32'h77777777,
		32'h7777777f, 32'h777f777f, 32'h777f7f7f, 32'h7f7f7f7f,
		32'h7f7f7fff, 32'h7fff7fff, 32'h7fffffff, 32'hffffffff
	};

endpackage

@@ src/ldbd_if.sv @@
// ----------------------------------------------------------------------------
// ldbd channel interfaces
// command channel and result channel of the lamp driver, valid/ready
// ----------------------------------------------------------------------------
interface ldbd_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [31:0] lamp_mask;
	logic        slow_phase_on;
	logic        fast_phase_on;
	logic        set_on;
	logic        set_blink_slow;
	logic        set_blink_fast;
	logic [4:0]  lamp_index;
	logic [7:0]  brightness;

	modport source (
		output valid, action, lamp_mask, slow_phase_on, fast_phase_on, set_on,
			set_blink_slow, set_blink_fast, lamp_index, brightness,
		input  ready
	);
	modport sink (
		input  valid, action, lamp_mask, slow_phase_on, fast_phase_on, set_on,
			set_blink_slow, set_blink_fast, lamp_index, brightness,
		output ready
	);
endinterface

interface ldbd_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] drive_value;
	logic [31:0] update_mask;

	modport source (output valid, drive_value, update_mask, input ready);
	modport sink (input valid, drive_value, update_mask, output ready);
endinterface

@@ src/lamp_dither_blink_driver_top.sv @@
// ----------------------------------------------------------------------------
// lamp_dither_blink_driver_top
// dither/blink driver for up to 32 lamps in 8-lamp wings; dither patterns
// live in a one-port-write, one-port-read synchronous memory
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | beat contents
//  cmd     | in  | valid/ready     | action, lamp_mask, phases, set bits, index, level
//  res     | out | valid/ready     | drive_value, update_mask (enabled ticks only)
//  cfg     | in  | cfg_we, no wait | cfg_index selects enable / valid / high-side mask
//
//  tick and rotations: accept, one memory read per lamp, drain of the read
//  register, finish; on, off, blink slow/fast, set on/off and combined set:
//  accept, then a write walk over the pattern memory
//  blink off and brightness write: taken in idle, no walk
//  reset takes effect at once: per-entry valid bits make unwritten patterns read zero
//  a finished tick waits in its finish state while a full result is not taken;
//  other commands are taken while a result waits
// ----------------------------------------------------------------------------
`include "lamp_dither_blink_driver_top_defines.svh"

module lamp_dither_blink_driver_top #(
	parameter int NUM_LAMPS = 32,
	parameter int NUM_WINGS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ldbd_cmd_if.sink                        cmd,
	ldbd_res_if.source                      res,
	input  logic                            cfg_we,
	input  logic [ldbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ldbd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(NUM_LAMPS);

	// configuration
	logic       enable_q;
	logic [3:0] valid_wing_q;
	logic [3:0] high_wing_q;

	// sequencer
	ldbd_pkg::state_t    state_q, state_d;
	ldbd_pkg::op_t       op_q, op_d;
	ldbd_pkg::action_t   act;
	logic [IDX_W-1:0]    cnt_q;
	logic                cnt_last;
	logic                accept;
	logic                walk_go;
	logic                rd_en;
	logic                res_free;
	logic                res_load;

	// stored item
	logic [NUM_LAMPS-1:0] sel_q;
	logic [NUM_LAMPS-1:0] sel_in;
	logic                 fill_ones_q;
	logic                 slow_ph_q;
	logic                 fast_ph_q;

	// lamp state
	logic [NUM_LAMPS-1:0] slow_bits_q;
	logic [NUM_LAMPS-1:0] fast_bits_q;
	logic [4:0]           phase_q;
	logic [NUM_LAMPS-1:0] lamps_q;

	// pattern memory and its read stage
	logic [31:0]          mem [NUM_LAMPS];
	logic [NUM_LAMPS-1:0] vld_q;
	logic [31:0]          rdata_s1;
	logic                 rvld_s1;
	logic                 rd_en_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [31:0]          rdata_eff;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_wa;
	logic [31:0]          mem_wd;

	// rotation bookkeeping
	logic                 rot_op;
	logic                 rot_step;
	logic                 seen_q;
	logic [31:0]          held_q;
	logic [IDX_W-1:0]     rot_idx_q;

	// result
	logic                 res_valid_q;
	logic [31:0]          drive_q;
	logic [31:0]          upd_q;
	logic [NUM_LAMPS-1:0] lamps_all;
	logic [31:0]          lamps32;
	logic [31:0]          drive_d;
	logic [31:0]          upd_d;

	assign act       = ldbd_pkg::action_t'(cmd.action);
	assign sel_in    = cmd.lamp_mask[NUM_LAMPS-1:0];
	assign cnt_last  = (cnt_q == IDX_W'(NUM_LAMPS - 1));
	assign accept    = cmd.valid && cmd.ready;
	assign res_free  = !res_valid_q || res.ready;
	assign rdata_eff = rvld_s1 ? rdata_s1 : 32'h0;
	assign rot_op    = (op_q == ldbd_pkg::OP_ROT_L) || (op_q == ldbd_pkg::OP_ROT_R);
	assign rot_step  = rd_en_s1 && rot_op && sel_q[idx_s1];

	// ------------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			valid_wing_q <= 4'h0;
			high_wing_q  <= 4'h0;
		end else if (cfg_we) begin
			case (cfg_index)
				ldbd_pkg::CFG_ENABLE:    enable_q     <= cfg_data[0];
				ldbd_pkg::CFG_VALID_WNG: valid_wing_q <= cfg_data[3:0];
				ldbd_pkg::CFG_HIGH_WNG:  high_wing_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// sequencer: decode in idle, walk the lamps, read walks drain and finish
	// ------------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		cmd.ready = 1'b0;
		walk_go   = 1'b0;
		rd_en     = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			ldbd_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					case (act)
						ldbd_pkg::ACT_TICK: begin
							if (enable_q) begin
								op_d    = ldbd_pkg::OP_TICK;
								state_d = ldbd_pkg::ST_READ;
								walk_go = 1'b1;
							end
						end
						ldbd_pkg::ACT_ROT_LEFT: begin
							op_d    = ldbd_pkg::OP_ROT_L;
							state_d = ldbd_pkg::ST_READ;
							walk_go = 1'b1;
						end
						ldbd_pkg::ACT_ROT_RIGHT: begin
							op_d    = ldbd_pkg::OP_ROT_R;
							state_d = ldbd_pkg::ST_READ;
							walk_go = 1'b1;
						end
						ldbd_pkg::ACT_ON, ldbd_pkg::ACT_OFF, ldbd_pkg::ACT_BLINK_SLOW,
						ldbd_pkg::ACT_BLINK_FAST, ldbd_pkg::ACT_COMBINED: begin
							op_d    = ldbd_pkg::OP_FILL;
							state_d = ldbd_pkg::ST_FILL;
							walk_go = 1'b1;
						end
						ldbd_pkg::ACT_SET_ON_OFF: begin
							op_d    = ldbd_pkg::OP_SETALL;
							state_d = ldbd_pkg::ST_FILL;
							walk_go = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ldbd_pkg::ST_READ: begin
				rd_en = 1'b1;
				if (cnt_last) begin
					state_d = ldbd_pkg::ST_DRAIN;
				end
			end
			ldbd_pkg::ST_DRAIN: begin
				state_d = ldbd_pkg::ST_FINISH;
			end
			ldbd_pkg::ST_FINISH: begin
				if (op_q != ldbd_pkg::OP_TICK) begin
					state_d = ldbd_pkg::ST_IDLE;
				end else if (res_free) begin
					res_load = 1'b1;
					state_d  = ldbd_pkg::ST_IDLE;
				end
			end
			ldbd_pkg::ST_FILL: begin
				if (cnt_last) begin
					state_d = ldbd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ldbd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldbd_pkg::ST_IDLE;
			op_q    <= ldbd_pkg::OP_TICK;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (walk_go) begin
				cnt_q <= '0;
			end else if (state_q == ldbd_pkg::ST_READ || state_q == ldbd_pkg::ST_FILL) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// item fields kept for the walk
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q       <= sel_in;
			slow_ph_q   <= cmd.slow_phase_on;
			fast_ph_q   <= cmd.fast_phase_on;
			// combined set with a blink request clears the pattern
			fill_ones_q <= (act == ldbd_pkg::ACT_ON) ||
				((act == ldbd_pkg::ACT_COMBINED) && cmd.set_on &&
				 !cmd.set_blink_slow && !cmd.set_blink_fast);
		end
	end

	// ------------------------------------------------------------------------
	// blink bitfields and pattern phase
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_bits_q <= '1;
			fast_bits_q <= '0;
			phase_q     <= 5'd0;
		end else begin
			if (accept) begin
				case (act)
					ldbd_pkg::ACT_BLINK_SLOW: begin
						slow_bits_q <= slow_bits_q | sel_in;
						fast_bits_q <= fast_bits_q & ~sel_in;
					end
					ldbd_pkg::ACT_BLINK_FAST: begin
						fast_bits_q <= fast_bits_q | sel_in;
						slow_bits_q <= slow_bits_q & ~sel_in;
					end
					ldbd_pkg::ACT_BLINK_OFF: begin
						slow_bits_q <= slow_bits_q & ~sel_in;
						fast_bits_q <= fast_bits_q & ~sel_in;
					end
					ldbd_pkg::ACT_SET_ON_OFF: begin
						slow_bits_q <= '0;
						fast_bits_q <= '0;
					end
					ldbd_pkg::ACT_COMBINED: begin
						if (cmd.set_blink_slow) begin
							slow_bits_q <= slow_bits_q | sel_in;
							fast_bits_q <= fast_bits_q & ~sel_in;
						end else if (cmd.set_blink_fast) begin
							fast_bits_q <= fast_bits_q | sel_in;
							slow_bits_q <= slow_bits_q & ~sel_in;
						end else begin
							slow_bits_q <= slow_bits_q & ~sel_in;
							fast_bits_q <= fast_bits_q & ~sel_in;
						end
					end
					default: ;
				endcase
			end
			if (res_load) begin
				phase_q <= phase_q + 5'd1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// pattern memory write port
	// ------------------------------------------------------------------------
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = 32'h0;
		if (accept && act == ldbd_pkg::ACT_BRIGHTNESS &&
		    ({1'b0, cmd.lamp_index} < 6'(NUM_LAMPS))) begin
			// brightness write: top five bits pick the dither pattern
			mem_we = 1'b1;
			mem_wa = cmd.lamp_index[IDX_W-1:0];
			mem_wd = ldbd_pkg::LEVEL_TABLE[cmd.brightness[7:3]];
		end else if (state_q == ldbd_pkg::ST_FILL) begin
			mem_wa = cnt_q;
			if (op_q == ldbd_pkg::OP_SETALL) begin
				mem_we = 1'b1;
				mem_wd = {32{sel_q[cnt_q]}};
			end else begin
				mem_we = sel_q[cnt_q];
				mem_wd = {32{fill_ones_q}};
			end
		end else if (rot_step && seen_q) begin
			mem_we = 1'b1;
			if (op_q == ldbd_pkg::OP_ROT_L) begin
				// pattern moves down to the previous selected lamp
				mem_wa = rot_idx_q;
				mem_wd = rdata_eff;
			end else begin
				// previous selected lamp's pattern moves up to this one
				mem_wa = idx_s1;
				mem_wd = held_q;
			end
		end else if (state_q == ldbd_pkg::ST_FINISH && rot_op && seen_q) begin
			// wrap: held pattern closes the ring
			mem_we = 1'b1;
			mem_wa = rot_idx_q;
			mem_wd = held_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rdata_s1 <= mem[cnt_q];
		end
		idx_s1 <= cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rvld_s1  <= 1'b0;
			rd_en_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			rd_en_s1 <= rd_en;
			if (rd_en) begin
				rvld_s1 <= vld_q[cnt_q];
			end
		end
	end

	// ------------------------------------------------------------------------
	// read-side processing: tick lamp bits and rotation carry
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (walk_go) begin
			seen_q <= 1'b0;
		end else if (rot_step) begin
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en_s1 && op_q == ldbd_pkg::OP_TICK) begin
			lamps_q[idx_s1] <= rdata_eff[phase_q];
		end
		if (rot_step) begin
			if (op_q == ldbd_pkg::OP_ROT_L) begin
				// keep the lowest pattern, track the last selected lamp
				if (!seen_q) begin
					held_q <= rdata_eff;
				end
				rot_idx_q <= idx_s1;
			end else begin
				// carry this pattern upward, remember the lowest lamp
				held_q <= rdata_eff;
				if (!seen_q) begin
					rot_idx_q <= idx_s1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result assembly: blink terms, per-wing inversion and update mask
	// ------------------------------------------------------------------------
	always_comb begin
		lamps_all = lamps_q | (slow_bits_q & {NUM_LAMPS{slow_ph_q}}) |
			(fast_bits_q & {NUM_LAMPS{fast_ph_q}});
		lamps32 = 32'(lamps_all);
		drive_d = 32'h0;
		upd_d   = 32'h0;
		for (int w = 0; w < NUM_WINGS; w++) begin
			if (valid_wing_q[w]) begin
				drive_d[8*w +: 8] = lamps32[8*w +: 8] ^ {8{high_wing_q[w]}};
				upd_d[8*w +: 8]   = 8'hff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			drive_q <= drive_d;
			upd_q   <= upd_d;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.drive_value = drive_q;
	assign res.update_mask = upd_q;

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	`LDBD_ASSERT_NEXT(a_res_only_from_tick, !res_valid_q && !res_load, !res_valid_q, "result appeared without a finished tick")
	`LDBD_ASSERT_NOW(a_idle_write_is_brightness, mem_we && state_q == ldbd_pkg::ST_IDLE, accept && act == ldbd_pkg::ACT_BRIGHTNESS, "memory written in idle by something other than a brightness beat")
	`LDBD_ASSERT_NOW(a_read_stage_in_walk, rd_en_s1, state_q == ldbd_pkg::ST_READ || state_q == ldbd_pkg::ST_DRAIN, "read data stage active outside the read walk")
	`LDBD_ASSERT_NEXT(a_phase_advances, res_load, phase_q == 5'($past(phase_q) + 5'd1), "pattern phase did not advance after a tick")

endmodule
